@@ design/olw_pkg.sv @@
// Shared types and defaults for the octree leaf insert walker.
// Used by olw_ctrl, olw_datapath and the top level; no dependencies.
package olw_pkg;

  localparam int unsigned DefMaxDepth  = 10;
  localparam int unsigned DefNodeCount = 4096;

  localparam int unsigned CoordW = 10;
  localparam int unsigned DepthW = 4;
  localparam int unsigned LeafW  = 12;

  localparam logic [DepthW-1:0] DepthReset = 4'd10;

  // Status codes returned with each leaf
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture coordinate, restart at root
    logic read;     // issue memory reads for current node and slot
    logic advance;  // existing child: step down
    logic alloc;    // missing child: link a fresh node and step down
    logic clear;    // zero occupancy of the fresh node
    logic emit;     // load the result register
    logic fail;     // result is pool full
  } olw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic depth_zero;  // configured depth descends no levels
    logic hit;         // child slot occupied
    logic full;        // node pool exhausted
    logic lvl_last;    // current level is the leaf level
    logic lvl_done;    // no levels left
  } olw_stat_t;

endpackage

@@ design/olw_ctrl.sv @@
// Walk sequencer: per-level lookup / check / allocate / clear steps and handshakes.
// Depends on olw_pkg.
module olw_ctrl
  import olw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  olw_stat_t stat_i,
  output olw_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.depth_zero ? ST_DONE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.hit) begin
          cmd_o.advance = 1'b1;
          state_d       = stat_i.lvl_last ? ST_DONE : ST_LOOKUP;
        end else if (stat_i.full) begin
          state_d = ST_FULL;
        end else begin
          cmd_o.alloc = 1'b1;
          state_d     = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = stat_i.lvl_done ? ST_DONE : ST_LOOKUP;
      end
      ST_DONE, ST_FULL: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.fail  = (state_q == ST_FULL);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/olw_datapath.sv @@
// Walker datapath: depth register, coordinate shifters, node pointer, bump pool
// and the child, parent and occupancy memories. Depends on olw_pkg.
module olw_datapath
  import olw_pkg::*;
#(
  parameter int unsigned LEVEL_LIMIT = DefMaxDepth,
  parameter int unsigned NODE_COUNT  = DefNodeCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DepthW-1:0] cfg_wdata_i,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic [CoordW-1:0] coord_z_i,
  input  olw_cmd_t          cmd_i,
  output olw_stat_t         stat_o,
  output logic [LeafW-1:0]  leaf_index_o,
  output logic              status_o
);

  localparam int unsigned IdxW = $clog2(NODE_COUNT);
  localparam int unsigned CntW = $clog2(NODE_COUNT + 1);
  localparam int unsigned DepW = $clog2(LEVEL_LIMIT + 1);
  localparam int unsigned CrdW = LEVEL_LIMIT;

  logic [DepthW-1:0] depth_q;
  logic [DepW-1:0]   depth_eff;
  logic [DepW-1:0]   align_sh;
  logic [DepW-1:0]   lvl_q;
  logic [CrdW-1:0]   cx_q, cy_q, cz_q;
  logic [CrdW-1:0]   cx_in, cy_in, cz_in;
  logic [IdxW-1:0]   node_q;
  logic [CntW-1:0]   used_q;
  logic [7:0]        root_occ_q;
  logic [7:0]        occ_rd_q;
  logic [IdxW-1:0]   child_rd_q;
  logic [7:0]        occ_val;
  logic [7:0]        slot_bit;
  logic [2:0]        slot;
  logic [IdxW-1:0]   new_idx;
  logic [LeafW-1:0]  leaf_q;
  logic              stat_q;

  logic [IdxW-1:0] child_mem [NODE_COUNT*8];
  logic [IdxW-1:0] parent_mem [NODE_COUNT];
  logic [7:0]      occ_mem [NODE_COUNT];

  // Saturate depth at LEVEL_LIMIT
  always_comb begin
    logic [DepW+DepthW-1:0] dx;
    dx = {{DepW{1'b0}}, depth_q};
    if (dx > (DepW+DepthW)'(LEVEL_LIMIT)) depth_eff = DepW'(LEVEL_LIMIT);
    else                                  depth_eff = dx[DepW-1:0];
  end

  assign align_sh = DepW'(LEVEL_LIMIT) - depth_eff;

  // Fit coordinates to LEVEL_LIMIT bits, then left-align the used bits
  always_comb begin
    logic [CrdW+CoordW-1:0] ex, ey, ez;
    ex    = {{CrdW{1'b0}}, coord_x_i};
    ey    = {{CrdW{1'b0}}, coord_y_i};
    ez    = {{CrdW{1'b0}}, coord_z_i};
    cx_in = ex[CrdW-1:0] << align_sh;
    cy_in = ey[CrdW-1:0] << align_sh;
    cz_in = ez[CrdW-1:0] << align_sh;
  end

  assign slot     = {cz_q[CrdW-1], cy_q[CrdW-1], cx_q[CrdW-1]};
  assign slot_bit = 8'd1 << slot;
  assign occ_val  = (node_q == '0) ? root_occ_q : occ_rd_q;
  assign new_idx  = used_q[IdxW-1:0];

  assign stat_o.depth_zero = (depth_eff == '0);
  assign stat_o.hit        = |(occ_val & slot_bit);
  assign stat_o.full       = (used_q >= CntW'(NODE_COUNT));
  assign stat_o.lvl_last   = (lvl_q == DepW'(1));
  assign stat_o.lvl_done   = (lvl_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= DepthReset;
      used_q     <= CntW'(1);
      root_occ_q <= '0;
    end else begin
      if (cfg_we_i) depth_q <= cfg_wdata_i;
      if (cmd_i.alloc) begin
        used_q <= used_q + CntW'(1);
        if (node_q == '0) root_occ_q <= root_occ_q | slot_bit;
      end
    end
  end

  // Walk registers: coordinates, level count and node pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q   <= cx_in;
      cy_q   <= cy_in;
      cz_q   <= cz_in;
      lvl_q  <= depth_eff;
      node_q <= '0;
    end else if (cmd_i.advance || cmd_i.alloc) begin
      cx_q   <= cx_q << 1;
      cy_q   <= cy_q << 1;
      cz_q   <= cz_q << 1;
      lvl_q  <= lvl_q - DepW'(1);
      node_q <= cmd_i.advance ? child_rd_q : new_idx;
    end
  end

  // Child store: read for lookup, write on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) child_rd_q <= child_mem[{node_q, slot}];
    if (cmd_i.alloc) child_mem[{node_q, slot}] <= new_idx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) parent_mem[new_idx] <= node_q;
  end

  // Occupancy store; the root lives in flip-flops, entry 0 is never used
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) occ_rd_q <= occ_mem[node_q];
    if (cmd_i.alloc && node_q != '0) occ_mem[node_q] <= occ_val | slot_bit;
    else if (cmd_i.clear)            occ_mem[node_q] <= '0;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      logic [LeafW+IdxW-1:0] nx;
      nx     = {{LeafW{1'b0}}, node_q};
      leaf_q <= cmd_i.fail ? '0 : nx[LeafW-1:0];
      stat_q <= cmd_i.fail ? STAT_FULL : STAT_OK;
    end
  end

  assign leaf_index_o = leaf_q;
  assign status_o     = stat_q;

endmodule

@@ design/octree_leaf_insert_walker_unit.sv @@
// Top level of the octree leaf insert walker: stream ports, config write port.
// Depends on olw_pkg, olw_ctrl and olw_datapath.
//
// Inserts one voxel coordinate per transfer into a sparse octree held in on-chip
// memories and returns the leaf node index. The walk starts at the root (node 0)
// and descends tree_depth levels (saturated to LEVEL_LIMIT); at each level the
// child slot is {z, y, x} of that level's coordinate bit, most significant level
// first. A missing child is taken from a bump pool, linked to its parent and
// marked in the parent's occupancy. When the pool is exhausted the result is
// leaf 0 with tuser set, and nodes allocated earlier in the walk stay linked.
// Steps: each level is a memory read, then a check, when the child exists, and
// read, link write and occupancy clear of the new node when it is allocated; the
// clear is a step of its own since the occupancy memory has a single write port.
// One item is walked at a time; the next is accepted while the previous result
// still waits in the output register. No clearing pass is needed after reset:
// the root occupancy is in flip-flops and every other node is cleared when
// allocated.
// Write tree_depth only while no walk is in progress.
module octree_leaf_insert_walker_unit
  import olw_pkg::*;
#(
  parameter int unsigned LEVEL_LIMIT = DefMaxDepth,
  parameter int unsigned NODE_COUNT  = DefNodeCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: tree_depth
  input  logic              cfg_we_i,
  input  logic [DepthW-1:0] cfg_wdata_i,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // coord_x [9:0], coord_y [19:10], coord_z [29:20]
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // leaf_index [11:0]
  output logic              m_axis_tuser    // status [0]: pool full
);

  olw_cmd_t         cmd;
  olw_stat_t        stat;
  logic [LeafW-1:0] leaf_index;

  // Sequencer: owns both handshakes and the step order of a walk
  olw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: coordinates are sampled from tdata on the load command only
  olw_datapath #(
    .LEVEL_LIMIT(LEVEL_LIMIT),
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coord_x_i   (s_axis_tdata[9:0]),
    .coord_y_i   (s_axis_tdata[19:10]),
    .coord_z_i   (s_axis_tdata[29:20]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .leaf_index_o(leaf_index),
    .status_o    (m_axis_tuser)
  );

  // Pad the leaf index to whole bytes
  assign m_axis_tdata = {4'b0000, leaf_index};

endmodule
